@@ hdl/mpts_pkg.sv @@
// Shared types and constants for the multi-policy task scheduler.
`timescale 1ns / 1ps
package mpts_pkg;
	localparam int MAX_SLOTS_DEF = 16;

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_TERM = 2'd2;

	localparam logic [1:0] POL_RR = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;
	localparam logic [1:0] POL_SJF = 2'd2;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_ACTIVE = 2'd2;

	typedef struct packed {
		logic load;
		logic charge;
		logic scan_start;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} sts_t;
endpackage

@@ hdl/mpts_datapath.sv @@
// Slot table, scan unit and selection registers of the scheduler.
`timescale 1ns / 1ps
module mpts_datapath #(
	parameter int MAX_SLOTS = mpts_pkg::MAX_SLOTS_DEF,
	localparam int SW = $clog2(MAX_SLOTS),
	localparam int CW = $clog2(MAX_SLOTS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  mpts_pkg::cmd_t cmd,
	output mpts_pkg::sts_t sts,
	input  logic [1:0] policy,
	input  logic [7:0] quantum,
	input  logic [4:0] active_slots,
	input  logic policy_wr,
	input  logic [3:0] in_slot,
	input  logic [15:0] in_run_time,
	output logic [3:0] chosen_slot,
	output logic chosen_valid,
	output logic switched,
	output logic finished,
	output logic [3:0] finished_slot
);
	localparam int MW = 2 * CW + 1;

	logic [1:0] state_q [MAX_SLOTS];
	logic [15:0] rem_q [MAX_SLOTS];
	logic [SW-1:0] cur_q;
	logic [7:0] qcnt_q;
	logic [CW-1:0] n_q, i_q;
	logic [SW-1:0] rr_q;
	logic rr_have_q, ff_have_q, sj_have_q, sj_any_q, keep_q, fin_q;
	logic [SW-1:0] rr_next_q, ff_next_q, sj_next_q, sj_best_q, fin_slot_q;
	logic [15:0] sj_bestrem_q;

	logic [CW-1:0] act_n;
	logic [1:0] st_i, st_rr, st_cur;
	logic [SW-1:0] i_idx, next;
	logic have;
	logic charge_end;
	logic [MW-1:0] rr_rem;

	assign act_n = (32'(active_slots) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(active_slots);
	assign i_idx = i_q[SW-1:0];
	assign st_i = state_q[i_idx];
	assign st_rr = state_q[rr_q];
	assign st_cur = state_q[cur_q];
	assign sts.scan_done = (i_q >= n_q);
	assign charge_end = (st_cur == mpts_pkg::ST_RUNNING) && (rem_q[cur_q] <= 16'd1);

	// start of the cyclic search: slot after the current one, wrapped at the active count
	always_comb begin
		rr_rem = MW'(cur_q) + MW'(1);
		for (int k = CW - 1; k >= 0; k--) begin
			if (act_n != '0 && rr_rem >= (MW'(act_n) << k))
				rr_rem = rr_rem - (MW'(act_n) << k);
		end
	end

	always_comb begin
		have = 1'b0;
		next = cur_q;
		if (policy == mpts_pkg::POL_RR) begin
			have = 1'b1;
			next = keep_q ? cur_q : (rr_have_q ? rr_next_q : cur_q);
		end else if (policy == mpts_pkg::POL_FIFO) begin
			have = ff_have_q;
			next = ff_next_q;
		end else if (policy == mpts_pkg::POL_SJF) begin
			have = sj_have_q || sj_any_q;
			next = sj_have_q ? sj_next_q : sj_best_q;
		end
		if (!have || state_q[next] == mpts_pkg::ST_TERM) begin
			if (ff_have_q) begin
				next = ff_next_q;
				have = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SLOTS; k++) state_q[k] <= mpts_pkg::ST_TERM;
			cur_q <= '0;
			qcnt_q <= '0;
			i_q <= '0;
			n_q <= '0;
			rr_q <= '0;
			{rr_have_q, ff_have_q, sj_have_q, sj_any_q, keep_q, fin_q} <= '0;
			chosen_slot <= '0;
			chosen_valid <= 1'b0;
			switched <= 1'b0;
			finished <= 1'b0;
			finished_slot <= '0;
		end else begin
			if (policy_wr) qcnt_q <= '0;
			if (cmd.load) begin
				if (32'(in_slot) < MAX_SLOTS) state_q[in_slot[SW-1:0]] <= mpts_pkg::ST_READY;
				chosen_slot <= 4'(cur_q);
				{chosen_valid, switched, finished} <= '0;
				finished_slot <= '0;
			end
			if (cmd.charge) begin
				fin_q <= charge_end;
				fin_slot_q <= charge_end ? cur_q : '0;
				if (charge_end) state_q[cur_q] <= mpts_pkg::ST_TERM;
			end
			if (cmd.scan_start) begin
				n_q <= act_n;
				i_q <= '0;
				keep_q <= (st_cur == mpts_pkg::ST_RUNNING) && !charge_end
					&& (qcnt_q < quantum);
				rr_q <= (act_n == '0) ? cur_q : rr_rem[SW-1:0];
				{rr_have_q, ff_have_q, sj_have_q, sj_any_q} <= '0;
			end
			if (cmd.scan_step && !sts.scan_done) begin
				i_q <= i_q + 1'b1;
				if (!rr_have_q && st_rr != mpts_pkg::ST_TERM) begin
					rr_have_q <= 1'b1;
					rr_next_q <= rr_q;
				end
				rr_q <= (32'(rr_q) + 1 >= 32'(n_q)) ? '0 : rr_q + 1'b1;
				if (st_i != mpts_pkg::ST_TERM) begin
					if (!ff_have_q) begin
						ff_have_q <= 1'b1;
						ff_next_q <= i_idx;
					end
					if (!sj_have_q) begin
						if (st_i == mpts_pkg::ST_RUNNING) begin
							sj_have_q <= 1'b1;
							sj_next_q <= i_idx;
						end else if (!sj_any_q || rem_q[i_idx] < sj_bestrem_q) begin
							sj_any_q <= 1'b1;
							sj_best_q <= i_idx;
							sj_bestrem_q <= rem_q[i_idx];
						end
					end
				end
			end
			if (cmd.commit) begin
				if (policy == mpts_pkg::POL_RR)
					qcnt_q <= keep_q ? qcnt_q + 1'b1 : 8'd1;
				finished <= fin_q;
				finished_slot <= 4'(fin_slot_q);
				if (have) cur_q <= next;
				chosen_slot <= 4'(have ? next : cur_q);
				if (!have || state_q[next] == mpts_pkg::ST_TERM) begin
					chosen_valid <= 1'b0;
					switched <= 1'b0;
				end else begin
					chosen_valid <= 1'b1;
					switched <= (next != cur_q) || (state_q[next] != mpts_pkg::ST_RUNNING);
					if (next != cur_q && st_cur != mpts_pkg::ST_TERM)
						state_q[cur_q] <= mpts_pkg::ST_READY;
					state_q[next] <= mpts_pkg::ST_RUNNING;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && 32'(in_slot) < MAX_SLOTS) rem_q[in_slot[SW-1:0]] <= in_run_time;
		if (cmd.charge && st_cur == mpts_pkg::ST_RUNNING)
			rem_q[cur_q] <= (rem_q[cur_q] != 16'd0) ? rem_q[cur_q] - 16'd1 : 16'd0;
	end
endmodule

@@ hdl/mpts_ctrl.sv @@
// Controller state machine sequencing load and tick beats.
`timescale 1ns / 1ps
module mpts_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_command,
	input  logic out_busy,
	input  logic out_fire,
	input  mpts_pkg::sts_t sts,
	output mpts_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_set
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHARGE = 5'b00010,
		S_SCAN = 5'b00100,
		S_COMMIT = 5'b01000,
		S_HOLD = 5'b10000
	} st_t;
	st_t st_q, st_d;

	always_comb begin
		st_d = st_q;
		cmd = '0;
		in_ready = 1'b0;
		out_set = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = !out_busy || out_fire;
				if (in_fire) begin
					if (in_command) begin
						cmd.load = 1'b1;
						out_set = 1'b1;
					end else st_d = S_CHARGE;
				end
			end
			S_CHARGE: begin
				cmd.charge = 1'b1;
				st_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) st_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!out_busy || out_fire) begin
					cmd.commit = 1'b1;
					out_set = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
		if (st_q == S_CHARGE) cmd.scan_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end
endmodule

@@ hdl/multi_policy_task_scheduler.sv @@
// Top level of the multi-policy task scheduler.
// Load beat: result registered on acceptance; the next beat is taken once the result beat is taken.
// Tick beat: charge, scan of active_slots (one slot a cycle), commit;
// commit waits until the result beat is free, and a new tick is taken only back in idle.
// Reset: all slots terminated, current slot 0, policy 0, quantum 4, active 0.
`timescale 1ns / 1ps
module multi_policy_task_scheduler #(
	parameter int MAX_SLOTS = mpts_pkg::MAX_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata, // slot[3:0], run_time[19:4]
	input  logic s_tuser,        // command
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata, // chosen_slot, chosen_valid, switched, finished, finished_slot
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	mpts_pkg::cmd_t cmd;
	mpts_pkg::sts_t sts;
	logic [1:0] policy_q;
	logic [7:0] quantum_q;
	logic [4:0] active_q;
	logic in_fire, out_fire, out_set, pol_wr;
	logic [3:0] cs, fs;
	logic cv, sw, fin;

	assign cfg_ready = 1'b1;
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign pol_wr = cfg_valid && cfg_index == mpts_pkg::REG_POLICY;
	assign m_tdata = {5'd0, fs, fin, sw, cv, cs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= mpts_pkg::POL_RR;
			quantum_q <= 8'd4;
			active_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					mpts_pkg::REG_POLICY: policy_q <= cfg_data[1:0];
					mpts_pkg::REG_QUANTUM: quantum_q <= cfg_data;
					mpts_pkg::REG_ACTIVE: active_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (out_set) m_tvalid <= 1'b1;
			else if (out_fire) m_tvalid <= 1'b0;
		end
	end

	mpts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_command(s_tuser),
		.out_busy(m_tvalid), .out_fire(out_fire), .sts(sts), .cmd(cmd),
		.in_ready(s_tready), .out_set(out_set)
	);

	mpts_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .policy(policy_q),
		.quantum(quantum_q), .active_slots(active_q), .policy_wr(pol_wr),
		.in_slot(s_tdata[3:0]), .in_run_time(s_tdata[19:4]),
		.chosen_slot(cs), .chosen_valid(cv), .switched(sw),
		.finished(fin), .finished_slot(fs)
	);
endmodule

@@ tb/sv/multi_policy_task_scheduler_check.sv @@
// Checker for the multi-policy task scheduler: predicts each result beat and compares it.
`timescale 1ns / 1ps
module multi_policy_task_scheduler_check (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [23:0] s_tdata,
	input  logic s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [15:0] m_tdata,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int errors,
	output int pending,
	output int loads,
	output int ticks,
	output int results
);
	import mpts_pkg::*;

	typedef struct packed {
		logic [3:0] finished_slot;
		logic finished;
		logic switched;
		logic chosen_valid;
		logic [3:0] chosen_slot;
	} sched_result_t;

	logic [1:0] slot_st [16];
	logic [15:0] slot_left [16];
	int cur_slot;
	int slice_used;
	logic [1:0] policy;
	logic [7:0] quantum;
	logic [4:0] active;
	sched_result_t expected_q [$];

	assign pending = expected_q.size();

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	function automatic sched_result_t schedule(input logic cmd, input logic [3:0] sl,
			input logic [15:0] rt);
		sched_result_t r;
		int c, n, i, idx, nxt, best;
		bit have, any;
		r = '0;
		c = cur_slot;
		have = 0;
		any = 0;
		nxt = 0;
		best = 0;
		if (cmd) begin
			slot_st[sl] = ST_READY;
			slot_left[sl] = rt;
			r.chosen_slot = 4'(c);
			return r;
		end
		if (slot_st[c] == ST_RUNNING) begin
			if (slot_left[c] <= 1) begin
				slot_st[c] = ST_TERM;
				r.finished = 1;
				r.finished_slot = 4'(c);
			end
			if (slot_left[c] != 0)
				slot_left[c] = slot_left[c] - 16'd1;
		end
		n = (active > 16) ? 16 : int'(active);
		case (policy)
			POL_RR: begin
				if (slot_st[c] == ST_RUNNING && slice_used < quantum) begin
					slice_used++;
					nxt = c;
					have = 1;
				end else begin
					slice_used = 1;
					for (i = 1; i <= n && !have; i++) begin
						idx = (c + i) % n;
						if (slot_st[idx] != ST_TERM) begin
							nxt = idx;
							have = 1;
						end
					end
					if (!have) begin
						nxt = c;
						have = 1;
					end
				end
			end
			POL_FIFO: begin
				for (i = 0; i < n && !have; i++)
					if (slot_st[i] != ST_TERM) begin
						nxt = i;
						have = 1;
					end
			end
			POL_SJF: begin
				for (i = 0; i < n && !have; i++) begin
					if (slot_st[i] == ST_RUNNING) begin
						nxt = i;
						have = 1;
					end else if (slot_st[i] != ST_TERM &&
							(!any || slot_left[i] < slot_left[best])) begin
						best = i;
						any = 1;
					end
				end
				if (!have && any) begin
					nxt = best;
					have = 1;
				end
			end
			default: ;
		endcase
		if (!have || slot_st[nxt] == ST_TERM) begin
			for (i = 0; i < n; i++)
				if (slot_st[i] != ST_TERM) begin
					nxt = i;
					have = 1;
					break;
				end
		end
		if (have)
			cur_slot = nxt;
		if (!have || slot_st[nxt] == ST_TERM) begin
			r.chosen_slot = 4'(cur_slot);
			return r;
		end
		r.switched = (nxt != c || slot_st[nxt] != ST_RUNNING);
		if (nxt != c && slot_st[c] != ST_TERM)
			slot_st[c] = ST_READY;
		slot_st[nxt] = ST_RUNNING;
		r.chosen_slot = 4'(nxt);
		r.chosen_valid = 1;
		return r;
	endfunction

	initial begin
		errors = 0;
		loads = 0;
		ticks = 0;
		results = 0;
		foreach (slot_st[i]) begin
			slot_st[i] = ST_TERM;
			slot_left[i] = '0;
		end
		cur_slot = 0;
		slice_used = 0;
		policy = POL_RR;
		quantum = 8'd4;
		active = '0;
	end

	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLICY: begin
						policy = cfg_data[1:0];
						slice_used = 0;
					end
					REG_QUANTUM: quantum = cfg_data;
					REG_ACTIVE: active = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(schedule(s_tuser, s_tdata[3:0], s_tdata[19:4]));
				if (s_tuser)
					loads++;
				else
					ticks++;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[10:0];
				results++;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected beat, chosen_slot", got.chosen_slot, 0);
				end else begin
					want = expected_q.pop_front();
					if (got.chosen_slot !== want.chosen_slot)
						report_mismatch("chosen_slot", got.chosen_slot, want.chosen_slot);
					if (got.chosen_valid !== want.chosen_valid)
						report_mismatch("chosen_valid", got.chosen_valid, want.chosen_valid);
					if (got.switched !== want.switched)
						report_mismatch("switched", got.switched, want.switched);
					if (got.finished !== want.finished)
						report_mismatch("finished", got.finished, want.finished);
					if (got.finished_slot !== want.finished_slot)
						report_mismatch("finished_slot", got.finished_slot,
							want.finished_slot);
				end
			end
		end
	end
endmodule

@@ tb/sv/multi_policy_task_scheduler_test.sv @@
// Stimulus and verdict for the multi-policy task scheduler across policies and settings.
`timescale 1ns / 1ps
module multi_policy_task_scheduler_test;
	import mpts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_POLICY;
	logic [7:0] cfg_data = '0;

	int errors, pending, loads, ticks, results;
	int cycles = 0;
	int stall_left = 0;
	bit quiet = 0;

	always #1 clk = ~clk;

	multi_policy_task_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	multi_policy_task_scheduler_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors), .pending(pending), .loads(loads), .ticks(ticks),
		.results(results)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL multi_policy_task_scheduler");
			$finish;
		end
	end

	// result side: stall in bursts
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			m_tready <= arst_n;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= int'($urandom_range(0, 3));
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_beat(input logic cmd, input logic [3:0] sl, input logic [15:0] rt);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, rt, sl};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] pol, input logic [7:0] qt, input logic [7:0] act);
		drain();
		write_reg(REG_POLICY, {6'd0, pol});
		write_reg(REG_QUANTUM, qt);
		write_reg(REG_ACTIVE, act);
	endtask

	function automatic logic [15:0] pick_time();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	task automatic run_mix(input int count, input int lo_slot, input int hi_slot);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 3)
				send_beat(1'b1, 4'($urandom_range(lo_slot, hi_slot)), pick_time());
			else
				send_beat(1'b0, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		logic [1:0] pols [12] = '{POL_RR, POL_FIFO, POL_SJF, POL_RR, 2'd3, POL_SJF,
			POL_RR, POL_FIFO, POL_RR, POL_SJF, POL_FIFO, POL_RR};
		logic [7:0] quants [12] = '{8'd1, 8'd4, 8'd255, 8'd0, 8'd2, 8'd3,
			8'd255, 8'd7, 8'd3, 8'd1, 8'd5, 8'd2};
		logic [7:0] acts [12] = '{8'd16, 8'd5, 8'd16, 8'd8, 8'd16, 8'd31,
			8'd1, 8'd16, 8'd12, 8'd3, 8'd0, 8'd16};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no live slot, extremes of slot and time, each policy
		send_beat(1'b0, 4'd0, 16'd0);
		send_beat(1'b1, 4'd15, 16'hFFFF);
		send_beat(1'b0, 4'd0, 16'd0);
		set_mode(POL_RR, 8'd2, 8'd16);
		send_beat(1'b1, 4'd0, 16'd0);
		send_beat(1'b1, 4'd3, 16'd2);
		repeat (6) send_beat(1'b0, 4'd0, 16'd0);
		send_beat(1'b1, 4'd15, 16'd1);
		send_beat(1'b1, 4'd15, 16'd3);
		repeat (3) send_beat(1'b0, 4'd0, 16'd0);
		set_mode(POL_SJF, 8'd1, 8'd16);
		send_beat(1'b1, 4'd5, 16'd9);
		send_beat(1'b1, 4'd2, 16'd4);
		send_beat(1'b1, 4'd7, 16'd4);
		repeat (4) send_beat(1'b0, 4'd0, 16'd0);
		set_mode(POL_FIFO, 8'd0, 8'd0);
		send_beat(1'b0, 4'd0, 16'd0);

		for (int p = 0; p < 12; p++) begin
			if (p == 11)
				quiet = 1;
			set_mode(pols[p], quants[p], acts[p]);
			for (int s = 0; s < 16; s++)
				if ($urandom_range(0, 1))
					send_beat(1'b1, 4'(s), 16'($urandom_range(1, 10)));
			run_mix(125, 0, 15);
		end
		drain();

		$display("covered %0d loads and %0d ticks over twelve register settings", loads, ticks);
		$display("checked %0d result beats, %0d mismatches", results, errors);
		if (errors == 0)
			$display("PASS multi_policy_task_scheduler");
		else
			$display("FAIL multi_policy_task_scheduler");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/mpts_pkg.sv
hdl/mpts_datapath.sv
hdl/mpts_ctrl.sv
hdl/multi_policy_task_scheduler.sv
tb/sv/multi_policy_task_scheduler_check.sv
tb/sv/multi_policy_task_scheduler_test.sv
